[rtl/nrdiv_pkg.sv]
// Shared types and constants for the pipelined non-restoring unsigned divider.
// Used by every module of the divider; depends on nothing else.
package nrdiv_pkg;

   localparam int unsigned NRDIV_FIELD_W = 64;
   localparam int unsigned NRDIV_WIDTH   = 64;

   typedef struct packed {
      logic valid;
      logic zero_div;
   } nrdiv_ctl_type;

endpackage

[rtl/nrdiv_stage.sv]
// One registered step of non-restoring division: shift, add or subtract the divisor
// according to the sign of the partial remainder, and take one quotient bit.
// Depends on nrdiv_pkg.
module nrdiv_stage
   import nrdiv_pkg::*;
#(
   parameter int unsigned WIDTH = NRDIV_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  nrdiv_ctl_type       ctl_i,
   input  logic [WIDTH+1:0]    part_i,
   input  logic [WIDTH-1:0]    quot_i,
   input  logic [WIDTH-1:0]    dsor_i,
   input  logic [WIDTH-1:0]    dend_i,
   output nrdiv_ctl_type       ctl_o,
   output logic [WIDTH+1:0]    part_o,
   output logic [WIDTH-1:0]    quot_o,
   output logic [WIDTH-1:0]    dsor_o,
   output logic [WIDTH-1:0]    dend_o
);

   nrdiv_ctl_type     ctl_ff;
   logic [WIDTH+1:0]  part_ff, part_in, shifted;
   logic [WIDTH-1:0]  quot_ff, quot_in;
   logic [WIDTH-1:0]  dsor_ff;
   logic [WIDTH-1:0]  dend_ff;

   always_comb begin
      shifted = {part_i[WIDTH:0], quot_i[WIDTH-1]};
      if (part_i[WIDTH+1]) begin
         part_in = shifted + {2'b00, dsor_i};
      end else begin
         part_in = shifted - {2'b00, dsor_i};
      end
      quot_in = {quot_i[WIDTH-2:0], ~part_in[WIDTH+1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff <= part_in;
         quot_ff <= quot_in;
         dsor_ff <= dsor_i;
         dend_ff <= dend_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign part_o = part_ff;
   assign quot_o = quot_ff;
   assign dsor_o = dsor_ff;
   assign dend_o = dend_ff;

endmodule

[rtl/nrdiv_fixup.sv]
// Final correction of the non-restoring remainder, the zero-divisor override
// and the output register of the divider. Depends on nrdiv_pkg.
module nrdiv_fixup
   import nrdiv_pkg::*;
#(
   parameter int unsigned WIDTH = NRDIV_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  nrdiv_ctl_type       ctl_i,
   input  logic [WIDTH+1:0]    part_i,
   input  logic [WIDTH-1:0]    quot_i,
   input  logic [WIDTH-1:0]    dsor_i,
   input  logic [WIDTH-1:0]    dend_i,
   output nrdiv_ctl_type       ctl_o,
   output logic [WIDTH-1:0]    quot_o,
   output logic [WIDTH-1:0]    rem_o
);

   nrdiv_ctl_type     ctl_ff;
   logic [WIDTH-1:0]  quot_ff, quot_in;
   logic [WIDTH-1:0]  rem_ff, rem_in;
   logic [WIDTH+1:0]  fixed;

   always_comb begin
      if (part_i[WIDTH+1]) begin
         fixed = part_i + {2'b00, dsor_i};
      end else begin
         fixed = part_i;
      end
      if (ctl_i.zero_div) begin
         quot_in = '0;
         rem_in  = dend_i;
      end else begin
         quot_in = quot_i;
         rem_in  = fixed[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign quot_o = quot_ff;
   assign rem_o  = rem_ff;

endmodule

[rtl/nonrestoring_unsigned_divider.sv]
// Pipelined non-restoring unsigned divider, one quotient bit per register stage.
// The stages are an input register, WIDTH add/subtract stages and a
// correction stage that also holds the result word. Throughput is one word per cycle;
// the whole pipeline holds while a result waits for rsp_tready.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on nrdiv_pkg, nrdiv_stage and nrdiv_fixup.
module nonrestoring_unsigned_divider
   import nrdiv_pkg::*;
#(
   parameter int unsigned WIDTH = NRDIV_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2*NRDIV_FIELD_W-1:0]  req_tdata,  // dividend, divisor
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2*NRDIV_FIELD_W-1:0]  rsp_tdata,  // quotient, remainder
   output logic                        rsp_tuser   // zero_divisor
);

   logic           advance;
   nrdiv_ctl_type  ctl_pipe  [0:WIDTH];
   logic [WIDTH+1:0] part_pipe [0:WIDTH];
   logic [WIDTH-1:0] quot_pipe [0:WIDTH];
   logic [WIDTH-1:0] dsor_pipe [0:WIDTH];
   logic [WIDTH-1:0] dend_pipe [0:WIDTH];

   nrdiv_ctl_type     in_ctl_ff, in_ctl_in, out_ctl;
   logic [WIDTH-1:0]  in_dend_ff, in_dsor_ff, out_quot, out_rem;

   assign advance    = ~out_ctl.valid | rsp_tready;
   assign req_tready = advance;

   always_comb begin
      in_ctl_in.valid    = req_tvalid;
      in_ctl_in.zero_div = (req_tdata[NRDIV_FIELD_W+WIDTH-1:NRDIV_FIELD_W] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (advance) begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_dend_ff <= req_tdata[WIDTH-1:0];
         in_dsor_ff <= req_tdata[NRDIV_FIELD_W+WIDTH-1:NRDIV_FIELD_W];
      end
   end

   assign ctl_pipe[0]  = in_ctl_ff;
   assign part_pipe[0] = '0;
   assign quot_pipe[0] = in_dend_ff;
   assign dsor_pipe[0] = in_dsor_ff;
   assign dend_pipe[0] = in_dend_ff;

   for (genvar i = 0; i < WIDTH; i++) begin : g_step
      nrdiv_stage #(
         .WIDTH(WIDTH)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (ctl_pipe[i]),
         .part_i  (part_pipe[i]),
         .quot_i  (quot_pipe[i]),
         .dsor_i  (dsor_pipe[i]),
         .dend_i  (dend_pipe[i]),
         .ctl_o   (ctl_pipe[i+1]),
         .part_o  (part_pipe[i+1]),
         .quot_o  (quot_pipe[i+1]),
         .dsor_o  (dsor_pipe[i+1]),
         .dend_o  (dend_pipe[i+1])
      );
   end

   nrdiv_fixup #(
      .WIDTH(WIDTH)
   ) u_fixup (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl_i   (ctl_pipe[WIDTH]),
      .part_i  (part_pipe[WIDTH]),
      .quot_i  (quot_pipe[WIDTH]),
      .dsor_i  (dsor_pipe[WIDTH]),
      .dend_i  (dend_pipe[WIDTH]),
      .ctl_o   (out_ctl),
      .quot_o  (out_quot),
      .rem_o   (out_rem)
   );

   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tuser  = out_ctl.zero_div;
   assign rsp_tdata  = {NRDIV_FIELD_W'(out_rem), NRDIV_FIELD_W'(out_quot)};

endmodule

[test/nonrestoring_unsigned_divider_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for nonrestoring_unsigned_divider: streams dividend/divisor words
// and checks each quotient, remainder and zero-divisor flag. Depends on nrdiv_pkg and the RTL.
module nonrestoring_unsigned_divider_tb;
   import nrdiv_pkg::*;

   localparam int unsigned WIDTH          = NRDIV_WIDTH;
   localparam int unsigned FW             = NRDIV_FIELD_W;
   localparam logic [FW-1:0] OPERAND_MASK = {FW{1'b1}} >> (FW - WIDTH);
   localparam int unsigned RANDOM_WORDS   = 1000;
   localparam int unsigned CALM_WORDS     = 150;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [FW-1:0] quotient;
      logic [FW-1:0] remainder;
      logic          zero_divisor;
   } division_result_type;

   class division_scoreboard;
      division_result_type pending_quotients[$];
      int unsigned         mismatches;
      int unsigned         checked;
      int unsigned         zero_divisor_seen;

      function division_result_type predict_division(logic [FW-1:0] dividend,
                                                     logic [FW-1:0] divisor);
         division_result_type res;
         logic [FW-1:0]       a;
         logic [FW-1:0]       b;
         a = dividend & OPERAND_MASK;
         b = divisor & OPERAND_MASK;
         res.zero_divisor = (b == '0);
         if (res.zero_divisor) begin
            res.quotient  = '0;
            res.remainder = a;
         end else begin
            res.quotient  = a / b;
            res.remainder = a % b;
         end
         return res;
      endfunction

      function void note_request(logic [FW-1:0] dividend, logic [FW-1:0] divisor);
         pending_quotients.push_back(predict_division(dividend, divisor));
      endfunction

      function void check_response(logic [FW-1:0] quotient, logic [FW-1:0] remainder,
                                   logic zero_divisor);
         division_result_type want;
         if (pending_quotients.size() == 0) begin
            $display("%0t: unexpected result word, actual q=%h r=%h zd=%b",
                     $time, quotient, remainder, zero_divisor);
            mismatches++;
            return;
         end
         want = pending_quotients.pop_front();
         checked++;
         if (zero_divisor) zero_divisor_seen++;
         if (quotient !== want.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time, want.quotient, quotient);
            mismatches++;
         end
         if (remainder !== want.remainder) begin
            $display("%0t: remainder expected %h actual %h", $time, want.remainder,
                     remainder);
            mismatches++;
         end
         if (zero_divisor !== want.zero_divisor) begin
            $display("%0t: zero_divisor expected %b actual %b", $time, want.zero_divisor,
                     zero_divisor);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [2*FW-1:0]  req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [2*FW-1:0]  rsp_tdata;
   logic             rsp_tuser;

   division_scoreboard ledger = new();
   bit                 idling_on = 1'b1;
   int unsigned        stall_left = 0;
   int unsigned        quiet_cycles = 0;
   int unsigned        words_sent = 0;

   nonrestoring_unsigned_divider #(.WIDTH(WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_response(rsp_tdata[FW-1:0], rsp_tdata[2*FW-1:FW], rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("nonrestoring_unsigned_divider_tb: done, errors");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the one that accepts the word.
   task automatic send_division(logic [FW-1:0] dividend, logic [FW-1:0] divisor);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(dividend, divisor);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [FW-1:0] random_operand();
      int unsigned   len;
      logic [FW-1:0] raw;
      len = $urandom_range(0, FW);
      raw = {$urandom, $urandom};
      if (len == 0) return '0;
      return raw >> (FW - len);
   endfunction

   initial begin
      logic [FW-1:0] top;
      logic [FW-1:0] msb;
      logic [FW-1:0] a;
      logic [FW-1:0] b;
      int unsigned   pick;

      top = OPERAND_MASK;
      msb = {1'b1, {FW-1{1'b0}}};
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero operands, divisor above dividend, exact quotients and the widest values.
      send_division('0, '0);
      send_division(64'd5, '0);
      send_division(top, '0);
      send_division('0, 64'd1);
      send_division('0, top);
      send_division(64'd1, 64'd1);
      send_division(top, 64'd1);
      send_division(top, top);
      send_division(64'd1, top);
      send_division(top - 1, top);
      send_division(top, 64'd2);
      send_division(top, 64'd3);
      send_division(msb, 64'd3);
      send_division(64'd7, 64'd3);
      send_division(64'd3, 64'd7);
      send_division(64'd100, 64'd10);
      send_division(top, msb);
      send_division(msb, msb + 1);
      send_division(msb - 1, msb);
      send_division(64'd12345, 64'd12345);
      send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

      for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - CALM_WORDS) idling_on = 1'b0;
         pick = $urandom_range(0, 15);
         a = random_operand();
         b = random_operand();
         if (pick == 0) begin
            b = '0;
         end else if (pick == 1) begin
            b = a;
         end else if (pick == 2) begin
            b = a + 1;
         end else if (pick == 3) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
         end else if (pick <= 6) begin
            a = {$urandom, $urandom};
            b = $urandom_range(1, 255);
         end
         send_division(a, b);
      end
      req_tvalid <= 1'b0;

      while (ledger.pending_quotients.size() != 0) @(posedge clock);
      repeat (WIDTH + 10) @(posedge clock);

      $display("Sent %0d division words, %0d directed at the edge cases, the rest random.",
               words_sent, 22);
      $display("Checked %0d results, %0d of them with a zero divisor; %0d mismatches.",
               ledger.checked, ledger.zero_divisor_seen, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.pending_quotients.size() == 0)
         $display("nonrestoring_unsigned_divider_tb: done, clean");
      else
         $display("nonrestoring_unsigned_divider_tb: done, errors");
      $finish;
   end

endmodule

[nonrestoring_unsigned_divider.f]
rtl/nrdiv_pkg.sv
rtl/nrdiv_stage.sv
rtl/nrdiv_fixup.sv
rtl/nonrestoring_unsigned_divider.sv
test/nonrestoring_unsigned_divider_tb.sv
